FILE: hw/rtl/tfw_pkg.sv
package tfw_pkg;

    localparam int VALUE_W     = 64;
    localparam int TAG_W       = 8;
    localparam int EVENT_W     = 3;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS);
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 64;

    typedef logic [1:0]            t_action;
    typedef logic [VALUE_W-1:0]    t_value;
    typedef logic [TAG_W-1:0]      t_tag;
    typedef logic [EVENT_W-1:0]    t_event;

    // input actions
    localparam t_action ACT_WAIT   = 2'd0;
    localparam t_action ACT_SIGNAL = 2'd1;
    localparam t_action ACT_TRY    = 2'd2;
    localparam t_action ACT_NONE   = 2'd3;

    // result events
    localparam t_event EV_RELEASED = 3'd0;
    localparam t_event EV_MET      = 3'd1;
    localparam t_event EV_PARKED   = 3'd2;
    localparam t_event EV_FULL     = 3'd3;
    localparam t_event EV_TRY      = 3'd4;
    localparam t_event EV_IGNORED  = 3'd5;
    localparam t_event EV_NONE     = 3'd6;

    // register index of start_value, taken from paddr[3]
    localparam logic REG_START_VALUE = 1'b0;

    typedef struct packed {
        t_action action;
        t_value  value;
        t_tag    tag;
    } t_item;

    typedef struct packed {
        logic   en;
        t_value value;
    } t_cfg_wr;

endpackage

FILE: hw/rtl/tfw_if.sv
interface tfw_in_if;
    logic                valid;
    logic                ready;
    tfw_pkg::t_action    action;
    tfw_pkg::t_value     value;
    tfw_pkg::t_tag       waiter_tag;

    modport source (output valid, action, value, waiter_tag, input ready);
    modport sink   (input valid, action, value, waiter_tag, output ready);
endinterface

interface tfw_out_if;
    logic                valid;
    logic                ready;
    tfw_pkg::t_event     event_res;
    tfw_pkg::t_tag       released_tag;
    logic                reached;
    logic                last;

    modport source (output valid, event_res, released_tag, reached, last, input ready);
    modport sink   (input valid, event_res, released_tag, reached, last, output ready);
endinterface

FILE: hw/rtl/tfw_front.sv
module tfw_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tfw_in_if.sink          i_in,
    output logic            o_q_valid,
    output tfw_pkg::t_item  o_q_item,
    input  logic            i_q_pop
);
    import tfw_pkg::*;

    t_item      r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_accept;
    logic       w_push;

    assign i_in.ready = (r_count != 2'd2);
    assign w_accept   = i_in.valid && i_in.ready;
    // drop the unused action here, it has no effect and no result
    assign w_push     = w_accept && (i_in.action != ACT_NONE);

    assign o_q_valid = (r_count != 2'd0);
    assign o_q_item  = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(w_push) - 2'(i_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= '{action: i_in.action, value: i_in.value, tag: i_in.waiter_tag};
        end
    end

endmodule

FILE: hw/rtl/tfw_back.sv
module tfw_back #(
    parameter int WAITER_SLOTS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  tfw_pkg::t_item   i_q_item,
    output logic             o_q_pop,
    input  tfw_pkg::t_cfg_wr i_cfg,
    tfw_out_if.source        o_out
);
    import tfw_pkg::*;

    localparam int SLOT_W = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;

    localparam logic ST_IDLE    = 1'b0;
    localparam logic ST_RELEASE = 1'b1;

    logic                    r_state;
    t_value                  r_fence;
    logic [WAITER_SLOTS-1:0] r_used;
    t_value                  r_target [WAITER_SLOTS];
    t_tag                    mem_tag  [WAITER_SLOTS];
    t_tag                    r_tag_rd;
    logic [WAITER_SLOTS-1:0] r_mask;
    logic [CNT_W-1:0]        r_count;

    logic                    r_out_valid;
    t_event                  r_out_ev;
    t_tag                    r_out_tag;
    logic                    r_out_reached;
    logic                    r_out_last;
    logic                    r_out_from_mem;

    logic                    w_out_free;
    logic                    w_pop;
    logic                    w_met;
    logic                    w_any_free;
    logic [SLOT_W-1:0]       w_free_idx;
    logic [WAITER_SLOTS-1:0] w_hit;
    logic [SLOT_W-1:0]       w_pick;
    logic [WAITER_SLOTS-1:0] w_rem;
    logic                    w_rel_last;
    logic                    w_park_we;
    logic                    w_rel_re;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_pop      = (r_state == ST_IDLE) && i_q_valid && w_out_free;
    assign o_q_pop    = w_pop;
    assign w_met      = (r_fence >= i_q_item.value);
    assign w_any_free = ~&r_used;

    // lowest free slot and lowest released slot
    always_comb begin
        w_free_idx = '0;
        w_pick     = '0;
        for (int i = WAITER_SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                w_free_idx = SLOT_W'(i);
            end
            if (r_mask[i]) begin
                w_pick = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < WAITER_SLOTS; i++) begin
            w_hit[i] = r_used[i] && (r_target[i] <= i_q_item.value);
        end
    end

    assign w_rem      = r_mask & ~({{(WAITER_SLOTS-1){1'b0}}, 1'b1} << w_pick);
    assign w_rel_last = (w_rem == '0) || (r_count == CNT_W'(MAX_RESULTS - 1));
    assign w_park_we  = w_pop && (i_q_item.action == ACT_WAIT) && !w_met && w_any_free;
    assign w_rel_re   = (r_state == ST_RELEASE) && w_out_free && (r_mask != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_used      <= '0;
            r_fence     <= '0;
        end else begin
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_pop) begin
                        r_out_valid    <= 1'b1;
                        r_out_last     <= 1'b1;
                        r_out_reached  <= 1'b0;
                        r_out_from_mem <= 1'b0;
                        r_out_tag      <= i_q_item.tag;
                        case (i_q_item.action)
                            ACT_WAIT: begin
                                if (w_met) begin
                                    r_out_ev <= EV_MET;
                                end else if (w_any_free) begin
                                    r_used[w_free_idx] <= 1'b1;
                                    r_out_ev           <= EV_PARKED;
                                end else begin
                                    r_out_ev <= EV_FULL;
                                end
                            end
                            ACT_SIGNAL: begin
                                r_out_tag <= '0;
                                if (i_q_item.value < r_fence) begin
                                    r_out_ev <= EV_IGNORED;
                                end else begin
                                    // snapshot the waiters to release, emit them next
                                    r_fence     <= i_q_item.value;
                                    r_mask      <= w_hit;
                                    r_count     <= '0;
                                    r_state     <= ST_RELEASE;
                                    r_out_valid <= 1'b0;
                                end
                            end
                            ACT_TRY: begin
                                r_out_ev      <= EV_TRY;
                                r_out_tag     <= '0;
                                r_out_reached <= w_met;
                            end
                            default: begin
                                r_out_valid <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_RELEASE: begin
                    if (w_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_reached <= 1'b0;
                        if (r_mask == '0) begin
                            r_out_ev       <= EV_NONE;
                            r_out_tag      <= '0;
                            r_out_from_mem <= 1'b0;
                            r_out_last     <= 1'b1;
                            r_state        <= ST_IDLE;
                        end else begin
                            r_out_ev       <= EV_RELEASED;
                            r_out_from_mem <= 1'b1;
                            r_out_last     <= w_rel_last;
                            r_used[w_pick] <= 1'b0;
                            r_mask         <= w_rem;
                            r_count        <= r_count + 1'b1;
                            if (w_rel_last) begin
                                r_state <= ST_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (i_cfg.en) begin
                r_fence <= i_cfg.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_park_we) begin
            r_target[w_free_idx] <= i_q_item.value;
        end
    end

    // tag store: registered read, advanced only together with the output register
    always_ff @(posedge i_clk) begin
        if (w_park_we) begin
            mem_tag[w_free_idx] <= i_q_item.tag;
        end
        if (w_rel_re) begin
            r_tag_rd <= mem_tag[w_pick];
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.event_res    = r_out_ev;
    assign o_out.released_tag = r_out_from_mem ? r_tag_rd : r_out_tag;
    assign o_out.reached      = r_out_reached;
    assign o_out.last         = r_out_last;

endmodule

FILE: hw/rtl/timeline_fence_waiter_table.sv
// Timeline fence with a table of parked waiters.
// i_in carries actions (wait, signal, try-wait) with a 64-bit value and a
// waiter tag; o_out carries result events, one or more per action, with the
// final one flagged by last. Both are valid/ready channels.
// The APB port holds start_value at address 0; writing it also loads the
// fence value at once. pready is always high.
// An accepted item is written into a two-entry queue and goes on from
// there to the output register. Wait, try-wait and an ignored signal
// each give one result. An accepted signal first snapshots the release
// mask; then the release sequencer gives one result per released waiter
// (at least one result), capped at 16 results, and reads the tag store
// once per released waiter. The unused action is dropped
// at the queue input and gives no result.
// Reset empties the queue and the table and sets the fence value to zero;
// there is no clearing pass. When the receiver stalls, the output register
// holds, the queue keeps taking items until both entries are full, and
// then i_in.ready drops.
module timeline_fence_waiter_table #(
    parameter int WAITER_SLOTS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    tfw_in_if.sink                           i_in,
    tfw_out_if.source                        o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tfw_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [tfw_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [tfw_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import tfw_pkg::*;

    t_value  r_start;
    t_cfg_wr w_cfg;
    logic    w_q_valid;
    t_item   w_q_item;
    logic    w_q_pop;
    logic    w_sel_start;

    assign pready      = 1'b1;
    assign w_sel_start = (paddr[3] == REG_START_VALUE);
    assign w_cfg.en    = psel && penable && pwrite && w_sel_start;
    assign w_cfg.value = pwdata;
    assign prdata      = w_sel_start ? r_start : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
        end else if (w_cfg.en) begin
            r_start <= pwdata;
        end
    end

    tfw_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (w_q_valid),
        .o_q_item  (w_q_item),
        .i_q_pop   (w_q_pop)
    );

    tfw_back #(
        .WAITER_SLOTS (WAITER_SLOTS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_q_pop),
        .i_cfg     (w_cfg),
        .o_out     (o_out)
    );

`ifndef NO_ASSERTIONS
    // take from the queue only when the output register can load
    a_pop_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> (w_q_valid && (!o_out.valid || o_out.ready)))
        else $error("queue popped while output blocked");

    // the queue never holds the unused action
    a_queue_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_valid |-> (w_q_item.action != ACT_NONE))
        else $error("unused action entered the queue");

    // only releases can be followed by more results of the same item
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.event_res != EV_RELEASED)) |-> o_out.last)
        else $error("non-release result without last");
`endif

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import tfw_pkg::*;

    localparam int WAITER_SLOTS    = 16;
    localparam int N_PHASES        = 6;
    localparam int PHASE_ITEMS     = 24;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int MAX_GAP         = 11;

    localparam logic [CFG_ADDR_W-1:0] START_VALUE_ADDR = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR       = 4'd8;

    typedef struct packed {
        t_event ev;
        t_tag   tag;
        logic   reached;
        logic   last;
    } t_fence_result;

    class fence_scoreboard;
        t_value        fence;
        bit            slot_busy  [WAITER_SLOTS];
        t_value        slot_goal  [WAITER_SLOTS];
        t_tag          slot_owner [WAITER_SLOTS];
        t_fence_result awaited_q[$];
        int            mismatches;

        function new();
            fence = '0;
            mismatches = 0;
            foreach (slot_busy[i]) slot_busy[i] = 1'b0;
        endfunction

        function void load_fence(t_value v);
            fence = v;
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction

        function void push(t_event ev, t_tag tag, logic reached, logic last);
            t_fence_result r;
            r.ev      = ev;
            r.tag     = tag;
            r.reached = reached;
            r.last    = last;
            awaited_q.push_back(r);
        endfunction

        // Advance the fence model by one accepted item and queue its results.
        function void note_item(t_action act, t_value v, t_tag tag);
            int            n;
            bit            placed;
            t_fence_result tail;
            n = 0;
            placed = 1'b0;
            case (act)
                ACT_WAIT: begin
                    if (fence >= v) begin
                        push(EV_MET, tag, 1'b0, 1'b1);
                    end else begin
                        for (int i = 0; i < WAITER_SLOTS && !placed; i++) begin
                            if (!slot_busy[i]) begin
                                slot_busy[i]  = 1'b1;
                                slot_goal[i]  = v;
                                slot_owner[i] = tag;
                                placed        = 1'b1;
                            end
                        end
                        push(placed ? EV_PARKED : EV_FULL, tag, 1'b0, 1'b1);
                    end
                end
                ACT_SIGNAL: begin
                    if (v < fence) begin
                        push(EV_IGNORED, '0, 1'b0, 1'b1);
                    end else begin
                        fence = v;
                        for (int i = 0; i < WAITER_SLOTS && n < MAX_RESULTS; i++) begin
                            if (slot_busy[i] && slot_goal[i] <= v) begin
                                slot_busy[i] = 1'b0;
                                push(EV_RELEASED, slot_owner[i], 1'b0, 1'b0);
                                n++;
                            end
                        end
                        if (n == 0) begin
                            push(EV_NONE, '0, 1'b0, 1'b1);
                        end else begin
                            tail = awaited_q.pop_back();
                            tail.last = 1'b1;
                            awaited_q.push_back(tail);
                        end
                    end
                end
                ACT_TRY: push(EV_TRY, '0, fence >= v, 1'b1);
                ACT_NONE: ;   // dropped, no result
            endcase
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(t_fence_result got);
            t_fence_result want;
            if (awaited_q.size() == 0) begin
                report($sformatf("unexpected result ev=%0d tag=%02h reached=%0b last=%0b",
                                 got.ev, got.tag, got.reached, got.last));
            end else begin
                want = awaited_q.pop_front();
                if (got.ev != want.ev)
                    report($sformatf("event_res %0d, want %0d", got.ev, want.ev));
                if (got.tag != want.tag)
                    report($sformatf("released_tag %02h, want %02h", got.tag, want.tag));
                if (got.reached != want.reached)
                    report($sformatf("reached %0b, want %0b", got.reached, want.reached));
                if (got.last != want.last)
                    report($sformatf("last %0b, want %0b", got.last, want.last));
            end
        endtask

        task check_leftover();
            if (awaited_q.size() != 0)
                report($sformatf("%0d results never arrived", awaited_q.size()));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    tfw_in_if  in_if ();
    tfw_out_if out_if ();

    fence_scoreboard sb = new();

    bit src_idle_on;
    bit snk_idle_on;
    bit hold_off_req;

    timeline_fence_waiter_table #(
        .WAITER_SLOTS (WAITER_SLOTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic apb_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == START_VALUE_ADDR) sb.load_fence(data);
        @(posedge i_clk);
    endtask

    task automatic apb_read_check(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata != want)
            sb.report($sformatf("start_value reads %016h, want %016h", prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_item(t_action act, t_value v, t_tag tag);
        int gap;
        gap = src_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.action     <= act;
        in_if.value      <= v;
        in_if.waiter_tag <= tag;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_item(act, v, tag);
    endtask

    // Mostly values near the fence so that waiters park and get released.
    task automatic send_random();
        int      pick;
        t_action act;
        t_value  v;
        t_value  f;
        t_tag    tag;
        f    = sb.fence;
        pick = $urandom_range(0, 99);
        tag  = t_tag'($urandom);
        v    = {$urandom, $urandom};
        if (pick < 45) begin
            act = ACT_WAIT;
            v   = (pick < 10) ? f - $urandom_range(0, 4) : f + $urandom_range(1, 30);
        end else if (pick < 70) begin
            act = ACT_SIGNAL;
            v   = (pick < 64) ? f + $urandom_range(0, 10) : f - $urandom_range(1, 8);
        end else if (pick < 85) begin
            act = ACT_TRY;
            v   = f + $urandom_range(0, 6) - 3;
        end else if (pick < 90) begin
            act = ACT_NONE;
        end else begin
            act = t_action'($urandom_range(0, 3));
        end
        send_item(act, v, tag);
    endtask

    // Drop valid and hold until every expected transfer has come back.
    task automatic drain(int settle);
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    initial begin : result_sink
        int            gap;
        t_fence_result got;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = snk_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (hold_off_req) begin
                gap = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            got.ev      = out_if.event_res;
            got.tag     = out_if.released_tag;
            got.reached = out_if.reached;
            got.last    = out_if.last;
            sb.check_result(got);
        end
    end

    initial begin : stimulus
        t_value settings [N_PHASES];
        t_value setting;
        int     cycles;

        settings = '{64'h0, '1, 64'hFFFF_FFFF_FFFF_FFE0, 64'h8000_0000_0000_0000,
                     64'h0, 64'h0000_0000_0000_1000};

        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        in_if.valid      <= 1'b0;
        in_if.action     <= ACT_NONE;
        in_if.value      <= '0;
        in_if.waiter_tag <= '0;
        src_idle_on      = 1'b1;
        snk_idle_on      = 1'b1;
        hold_off_req     = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: fence starts at its reset value of zero
        send_item(ACT_TRY, '0, 8'h00);
        send_item(ACT_TRY, '1, 8'h00);
        send_item(ACT_WAIT, '0, 8'hFF);
        send_item(ACT_NONE, '1, 8'hFF);
        send_item(ACT_SIGNAL, '0, 8'h00);        // equal to the fence: scans, none released
        for (int i = 0; i < WAITER_SLOTS; i++)
            send_item(ACT_WAIT, t_value'(WAITER_SLOTS - i), t_tag'(i * 17 + 3));
        send_item(ACT_WAIT, 64'd2, 8'h5A);       // table full
        send_item(ACT_SIGNAL, '1, 8'h00);        // releases the whole table
        send_item(ACT_SIGNAL, 64'd1, 8'h00);     // below the fence: ignored
        send_item(ACT_WAIT, '1, 8'h00);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain(SETTLE_CYCLES);
            setting = (ph == 4) ? {$urandom, $urandom} : settings[ph];
            if (ph == 2) apb_write(SPARE_ADDR, {$urandom, $urandom});
            apb_write(START_VALUE_ADDR, setting);
            apb_read_check(START_VALUE_ADDR, setting);
            src_idle_on = (ph % 3) != 2;
            snk_idle_on = (ph % 2) == 0;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 1 && k == 5) hold_off_req = 1'b1;
                if (ph == 3 && k == 12) drain(0);
                send_random();
            end
        end

        in_if.valid <= 1'b0;
        cycles = 0;
        while (sb.pending() != 0 && cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.check_leftover();
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/tfw_pkg.sv
hw/rtl/tfw_if.sv
hw/rtl/tfw_front.sv
hw/rtl/tfw_back.sv
hw/rtl/timeline_fence_waiter_table.sv
dv/tb.sv
